@@ sv/assert_macros.svh @@
// Assertion macros for the checker file.
// Depends on nothing; each user supplies clk and rst_n in its scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication that must hold whenever the guard is high
`define ASSERT_WHEN(label, guard, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (guard) |-> (expr)) \
        else $error(msg);

`endif

@@ sv/deq_pkg.sv @@
// Package for the double ended queue: sizes, operation and status codes, payload types.
// Used by the top level and by its checker.
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Operation codes carried in the mode field
    localparam logic [2:0] MODE_NONE       = 3'd0;
    localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd2;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [2:0] MODE_POP_REAR   = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]            mode;
        logic [DATA_WIDTH-1:0] value;
    } deq_op_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] removed_value;
        logic [DATA_WIDTH-1:0] front_value;
        logic [DATA_WIDTH-1:0] rear_value;
        logic [CNT_W-1:0]      entry_count;
        logic                  is_empty;
        logic [1:0]            status;
    } deq_res_t;

endpackage

@@ sv/double_ended_queue.sv @@
// Double ended queue top level: ring memory, end pointers, count and result register.
// Depends on deq_pkg.
//
// A request (mode and value) is taken when op_valid and op_ready are high; each request gives
// one result on res. Inserts, no-ops, refused inserts and removals from an empty queue or of
// the last element write the result register directly. A removal that leaves elements goes
// through the fetch state: the new front or rear value is read back from the element memory's
// registered read port and patched into the result. The front and rear values are kept in
// registers beside the memory, so results never wait for more than that single read. A new
// request is taken while the previous result is being taken in the same cycle.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     op_valid,
    output logic     op_ready,
    input  deq_op_t  op,
    output logic     res_valid,
    input  logic     res_ready,
    output deq_res_t res
);

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } state_t;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    state_t                state_reg;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [IDX_W-1:0]      rear_reg, rear_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_WIDTH-1:0] fval_reg, fval_next;
    logic [DATA_WIDTH-1:0] rval_reg, rval_next;
    logic                  fetch_front_reg;
    logic                  res_valid_reg;
    deq_res_t              res_reg, res_next;

    logic                  op_fire;
    logic                  wr_en, rd_en, fetch, fetch_front;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [IDX_W-1:0]      front_inc, front_dec, rear_inc, rear_dec;
    logic [DATA_WIDTH-1:0] removed;
    logic [1:0]            status;

    assign op_ready  = (state_reg == ST_IDLE) && (!res_valid_reg || res_ready);
    assign op_fire   = op_valid && op_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Ring neighbors of both ends
    assign front_inc = (front_reg == IDX_LAST) ? '0 : front_reg + IDX_W'(1);
    assign front_dec = (front_reg == '0) ? IDX_LAST : front_reg - IDX_W'(1);
    assign rear_inc  = (rear_reg == IDX_LAST) ? '0 : rear_reg + IDX_W'(1);
    assign rear_dec  = (rear_reg == '0) ? IDX_LAST : rear_reg - IDX_W'(1);

    // Decode the request: pointer moves, memory write or read, result
    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        count_next  = count_reg;
        fval_next   = fval_reg;
        rval_next   = rval_reg;
        wr_en       = 1'b0;
        wr_addr     = front_reg;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        fetch       = 1'b0;
        fetch_front = 1'b0;
        removed     = '0;
        status      = STAT_OK;
        unique case (op.mode)
            MODE_PUSH_REAR, MODE_PUSH_FRONT:
            begin
                if (count_reg == CNT_FULL) begin
                    status = STAT_FULL;
                end else if (count_reg == '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = front_reg;
                    rear_next  = front_reg;
                    count_next = CNT_ONE;
                    fval_next  = op.value;
                    rval_next  = op.value;
                end else if (op.mode == MODE_PUSH_REAR) begin
                    wr_en      = 1'b1;
                    wr_addr    = rear_inc;
                    rear_next  = rear_inc;
                    count_next = count_reg + CNT_ONE;
                    rval_next  = op.value;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + CNT_ONE;
                    fval_next  = op.value;
                end
            end
            MODE_POP_FRONT:
            begin
                if (count_reg == '0) begin
                    status = STAT_EMPTY;
                end else begin
                    removed    = fval_reg;
                    count_next = count_reg - CNT_ONE;
                    if (count_reg != CNT_ONE) begin
                        front_next  = front_inc;
                        rd_en       = 1'b1;
                        rd_addr     = front_inc;
                        fetch       = 1'b1;
                        fetch_front = 1'b1;
                    end else begin
                        rear_next = front_reg;
                    end
                end
            end
            MODE_POP_REAR:
            begin
                if (count_reg == '0) begin
                    status = STAT_EMPTY;
                end else begin
                    removed    = rval_reg;
                    count_next = count_reg - CNT_ONE;
                    if (count_reg != CNT_ONE) begin
                        rear_next = rear_dec;
                        rd_en     = 1'b1;
                        rd_addr   = rear_dec;
                        fetch     = 1'b1;
                    end else begin
                        front_next = rear_reg;
                    end
                end
            end
            default:
            begin
                status = STAT_OK;
            end
        endcase

        res_next.removed_value = removed;
        res_next.front_value   = (count_next != '0) ? fval_next : '0;
        res_next.rear_value    = (count_next != '0) ? rval_next : '0;
        res_next.entry_count   = count_next;
        res_next.is_empty      = (count_next == '0);
        res_next.status        = status;
    end

    // Element memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (op_fire && wr_en) begin
            mem[wr_addr] <= op.value;
        end
        if (op_fire && rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Hold state, pointers, cached end values and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            front_reg       <= '0;
            rear_reg        <= '0;
            count_reg       <= '0;
            fval_reg        <= '0;
            rval_reg        <= '0;
            fetch_front_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (op_fire) begin
                        front_reg       <= front_next;
                        rear_reg        <= rear_next;
                        count_reg       <= count_next;
                        fval_reg        <= fval_next;
                        rval_reg        <= rval_next;
                        fetch_front_reg <= fetch_front;
                        res_reg         <= res_next;
                        res_valid_reg   <= !fetch;
                        if (fetch) begin
                            state_reg <= ST_FETCH;
                        end
                    end else if (res_ready) begin
                        res_valid_reg <= 1'b0;
                    end
                end
                ST_FETCH:
                begin
                    // Patch the new end value read back from memory
                    if (fetch_front_reg) begin
                        fval_reg            <= rd_data_reg;
                        res_reg.front_value <= rd_data_reg;
                    end else begin
                        rval_reg           <= rd_data_reg;
                        res_reg.rear_value <= rd_data_reg;
                    end
                    res_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/deq_checker.sv @@
// Port-level checker for the double ended queue, bound to the top level.
// Depends on deq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module deq_checker
    import deq_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     op_valid,
    input logic     op_ready,
    input deq_op_t  op,
    input logic     res_valid,
    input logic     res_ready,
    input deq_res_t res
);

    // Stalled result holds
    `ASSERT_CLK(a_res_hold, (res_valid && !res_ready) |=> (res_valid && $stable(res)), "result changed while stalled")

    // Empty flag agrees with the count
    `ASSERT_WHEN(a_empty_flag, res_valid, res.is_empty == (res.entry_count == '0), "empty flag disagrees with count")

    // Count never exceeds the ring size
    `ASSERT_WHEN(a_count_max, res_valid, res.entry_count <= CNT_W'(DEPTH), "count above depth")

    // Empty queue shows zero at both ends
    `ASSERT_WHEN(a_empty_ends, res_valid && res.is_empty, (res.front_value == '0) && (res.rear_value == '0), "nonzero end value while empty")

    // Refused or failed requests remove nothing
    `ASSERT_WHEN(a_fail_nothing, res_valid && (res.status != STAT_OK), res.removed_value == '0, "value removed by failed request")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
